/* hw/rtl/sme_pkg.sv */
// Shared types and codes for the stack machine execute unit.
package sme_pkg;

   typedef enum logic [3:0] {
      CMD_NOP    = 4'd0,
      CMD_PUSH   = 4'd1,
      CMD_CALL   = 4'd2,
      CMD_POP    = 4'd3,
      CMD_ADD    = 4'd4,
      CMD_BRANCH = 4'd5,
      CMD_JUMP   = 4'd6,
      CMD_RETURN = 4'd7,
      CMD_PRINT  = 4'd8,
      CMD_DUP    = 4'd9,
      CMD_SHOW   = 4'd10,
      CMD_SLEEP  = 4'd11
   } cmd_type;

   typedef enum logic [2:0] {
      ERR_OK    = 3'd0,
      ERR_UNDER = 3'd1,
      ERR_OVER  = 3'd2,
      ERR_BADOP = 3'd3,
      ERR_RANGE = 3'd4
   } err_type;

   localparam int LEN_WIDTH = 13;
   localparam logic [LEN_WIDTH-1:0] LEN_RESET = 13'd4096;

   typedef enum logic [1:0] {
      SH_HOLD = 2'd0,
      SH_DOWN = 2'd1,
      SH_UP   = 2'd2
   } shift_op_type;

   typedef struct packed {
      shift_op_type top_op;
      shift_op_type rest_op;
   } shift_ctrl_type;

   typedef struct packed {
      logic        [3:0]  command;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic        [11:0] next_pc;
      logic signed [31:0] top_value;
      logic        [4:0]  stack_depth;
      logic               halted;
      logic        [2:0]  error_code;
   } rsp_type;

endpackage

/* hw/rtl/stack_machine_execute_unit.sv */
// Top level of the stack machine execute unit.
//
//  channel  direction  handshake      payload
//  req_     in         valid / stall  req_type (command, operand)
//  rsp_     out        valid / stall  rsp_type (next_pc .. error_code)
//  csr_     in         valid / ready  program_length, 13 bits
//
//  One instruction per cycle while req_stall is low; its result is registered.
//  The stack is a row of shift cells, top entry in cell 0.
//  Reset is synchronous: empty stack of zeros, pc 0, program length 4096.
//  A stalled result parks in a skid slot; req_stall rises only while that slot is full.
//  csr_ready is always high.
module stack_machine_execute_unit
   import sme_pkg::*;
#(
   parameter int STACK_DEPTH = 16,
   parameter int PC_WIDTH    = 12,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [LEN_WIDTH-1:0] csr_data
);

   logic                  accept;
   logic                  busy;
   shift_ctrl_type        shift;
   logic [DATA_WIDTH-1:0] new_top;
   rsp_type               result;
   logic [DATA_WIDTH-1:0] cell_value [STACK_DEPTH];

   assign csr_ready = 1'b1;
   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   sme_exec #(
      .STACK_DEPTH (STACK_DEPTH),
      .PC_WIDTH    (PC_WIDTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_exec (
      .clock     (clock),
      .reset     (reset),
      .cfg_write (csr_valid && csr_ready),
      .cfg_data  (csr_data),
      .accept    (accept),
      .req       (req_data),
      .top0      (cell_value[0]),
      .top1      (cell_value[1]),
      .shift     (shift),
      .new_top   (new_top),
      .result    (result)
   );

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] upper;
      logic [DATA_WIDTH-1:0] lower;
      shift_op_type          op;

      if (i == 0) begin : g_top
         assign upper = new_top;
         assign op    = shift.top_op;
      end else begin : g_body
         assign upper = cell_value[i-1];
         assign op    = shift.rest_op;
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         assign lower = '0;
      end else begin : g_inner
         assign lower = cell_value[i+1];
      end

      sme_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .op    (op),
         .upper (upper),
         .lower (lower),
         .value (cell_value[i])
      );
   end

   sme_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (result),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* hw/rtl/sme_cell.sv */
// One stack entry; shifts toward or away from the top with its neighbors.
module sme_cell
   import sme_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  shift_op_type          op,
   input  logic [DATA_WIDTH-1:0] upper,
   input  logic [DATA_WIDTH-1:0] lower,
   output logic [DATA_WIDTH-1:0] value
);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   always_comb begin
      case (op)
         SH_HOLD: value_in = value_ff;
         SH_DOWN: value_in = upper;
         SH_UP:   value_in = lower;
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

/* hw/rtl/sme_exec.sv */
// Instruction decode, pc and depth tracking, and stack shift control.
module sme_exec
   import sme_pkg::*;
#(
   parameter int STACK_DEPTH = 16,
   parameter int PC_WIDTH    = 12,
   parameter int DATA_WIDTH  = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cfg_write,
   input  logic [LEN_WIDTH-1:0]  cfg_data,
   input  logic                  accept,
   input  req_type               req,
   input  logic [DATA_WIDTH-1:0] top0,
   input  logic [DATA_WIDTH-1:0] top1,
   output shift_ctrl_type        shift,
   output logic [DATA_WIDTH-1:0] new_top,
   output rsp_type               result
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam logic [63:0] PC_LIM = 64'(1) << PC_WIDTH;

   logic [LEN_WIDTH-1:0] len_ff;
   logic [PC_WIDTH:0]    pc_ff;
   logic [PC_WIDTH:0]    pc_in;
   logic [DEPTH_W-1:0]   depth_ff;
   logic [DEPTH_W-1:0]   depth_in;

   logic [63:0]           len64;
   logic [PC_WIDTH:0]     len_eff;
   logic                  halted_now;
   logic [PC_WIDTH:0]     pc_plus;
   logic [PC_WIDTH:0]     target_pc;
   logic [PC_WIDTH:0]     return_pc;
   logic                  tgt_ok;
   logic                  ret_ok;
   logic                  empty;
   logic                  full;
   logic                  one_entry;
   logic [63:0]           push_ext;
   logic [63:0]           call_ext;
   logic [DATA_WIDTH-1:0] sum;
   logic [DATA_WIDTH-1:0] top_next;
   err_type               err;
   shift_ctrl_type        shift_raw;
   logic [63:0]           top_ext;
   logic [63:0]           top_next_ext;
   logic [63:0]           depth_ext;
   logic [63:0]           pc_ext;

   assign len64     = (64'(len_ff) < PC_LIM) ? 64'(len_ff) : PC_LIM;
   assign len_eff   = len64[PC_WIDTH:0];
   assign halted_now = pc_ff >= len_eff;
   assign pc_plus   = pc_ff + (PC_WIDTH+1)'(1);
   assign target_pc = {1'b0, req.operand[PC_WIDTH-1:0]};
   assign return_pc = top_ext[PC_WIDTH:0];
   assign tgt_ok    = !req.operand[31] && ({32'b0, req.operand} < len64);
   assign ret_ok    = top_ext <= len64;
   assign empty     = depth_ff == '0;
   assign one_entry = depth_ff == DEPTH_W'(1);
   assign full      = depth_ff >= DEPTH_W'(STACK_DEPTH);
   assign push_ext  = {{32{req.operand[31]}}, req.operand};
   assign call_ext  = 64'(pc_plus);
   assign sum       = top0 + top1;
   assign top_ext   = 64'(top0);

   always_comb begin
      err               = ERR_OK;
      pc_in             = pc_ff;
      depth_in          = depth_ff;
      shift_raw.top_op  = SH_HOLD;
      shift_raw.rest_op = SH_HOLD;
      new_top           = top0;
      if (!halted_now) begin
         case (cmd_type'(req.command))
            CMD_NOP, CMD_PRINT, CMD_SHOW, CMD_SLEEP: begin
               pc_in = pc_plus;
            end
            CMD_PUSH: begin
               if (full) begin
                  err = ERR_OVER;
               end else begin
                  new_top           = push_ext[DATA_WIDTH-1:0];
                  shift_raw.top_op  = SH_DOWN;
                  shift_raw.rest_op = SH_DOWN;
                  depth_in          = depth_ff + DEPTH_W'(1);
                  pc_in             = pc_plus;
               end
            end
            CMD_CALL: begin
               if (full) begin
                  err = ERR_OVER;
               end else if (!tgt_ok) begin
                  err = ERR_RANGE;
               end else begin
                  new_top           = call_ext[DATA_WIDTH-1:0];
                  shift_raw.top_op  = SH_DOWN;
                  shift_raw.rest_op = SH_DOWN;
                  depth_in          = depth_ff + DEPTH_W'(1);
                  pc_in             = target_pc;
               end
            end
            CMD_POP: begin
               if (empty) begin
                  err = ERR_UNDER;
               end else begin
                  shift_raw.top_op  = SH_UP;
                  shift_raw.rest_op = SH_UP;
                  depth_in          = depth_ff - DEPTH_W'(1);
                  pc_in             = pc_plus;
               end
            end
            CMD_ADD: begin
               if (empty || one_entry) begin
                  err = ERR_UNDER;
               end else begin
                  // sum lands in the top cell, the rest move up one
                  new_top           = sum;
                  shift_raw.top_op  = SH_DOWN;
                  shift_raw.rest_op = SH_UP;
                  depth_in          = depth_ff - DEPTH_W'(1);
                  pc_in             = pc_plus;
               end
            end
            CMD_BRANCH: begin
               if (empty) begin
                  err = ERR_UNDER;
               end else if (top0 == '0) begin
                  pc_in = pc_plus;
               end else if (!tgt_ok) begin
                  err = ERR_RANGE;
               end else begin
                  pc_in = target_pc;
               end
            end
            CMD_JUMP: begin
               if (!tgt_ok) begin
                  err = ERR_RANGE;
               end else begin
                  pc_in = target_pc;
               end
            end
            CMD_RETURN: begin
               if (empty) begin
                  err = ERR_UNDER;
               end else if (!ret_ok) begin
                  err = ERR_RANGE;
               end else begin
                  shift_raw.top_op  = SH_UP;
                  shift_raw.rest_op = SH_UP;
                  depth_in          = depth_ff - DEPTH_W'(1);
                  pc_in             = return_pc;
               end
            end
            CMD_DUP: begin
               if (empty) begin
                  err = ERR_UNDER;
               end else if (full) begin
                  err = ERR_OVER;
               end else begin
                  new_top           = top0;
                  shift_raw.top_op  = SH_DOWN;
                  shift_raw.rest_op = SH_DOWN;
                  depth_in          = depth_ff + DEPTH_W'(1);
                  pc_in             = pc_plus;
               end
            end
            default: begin
               err = ERR_BADOP;
            end
         endcase
      end
   end

   // drop the shift unless the instruction transfer really happens
   always_comb begin
      shift = shift_raw;
      if (!accept) begin
         shift.top_op  = SH_HOLD;
         shift.rest_op = SH_HOLD;
      end
   end

   always_comb begin
      case (shift_raw.top_op)
         SH_DOWN: top_next = new_top;
         SH_UP:   top_next = top1;
         default: top_next = top0;
      endcase
   end

   assign depth_ext    = 64'(depth_in);
   assign pc_ext       = 64'(pc_in[PC_WIDTH-1:0]);
   assign top_next_ext = 64'(top_next);

   always_comb begin
      result.next_pc     = pc_ext[11:0];
      result.top_value   = top_next_ext[31:0];
      result.stack_depth = depth_ext[4:0];
      result.halted      = pc_in >= len_eff;
      result.error_code  = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= LEN_RESET;
         pc_ff    <= '0;
         depth_ff <= '0;
      end else begin
         if (cfg_write) begin
            len_ff <= cfg_data;
         end
         if (accept) begin
            pc_ff    <= pc_in;
            depth_ff <= depth_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      64'(depth_ff) <= 64'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_pc_bound: assert property (@(posedge clock) disable iff (reset)
      64'(pc_ff) <= PC_LIM)
      else $error("pc beyond halt value");

   a_fault_holds: assert property (@(posedge clock) disable iff (reset)
      accept && err != ERR_OK |=> $stable(depth_ff) && $stable(pc_ff))
      else $error("faulting instruction changed state");

   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      accept && halted_now && !cfg_write |=> $stable(pc_ff) && $stable(depth_ff))
      else $error("halted machine changed state");
`endif

endmodule

/* hw/rtl/sme_outbuf.sv */
// Result register with a skid stage so input and output sides decouple.
module sme_outbuf
   import sme_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_data,
   output logic    busy,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    out_take;

   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_data;
         end
      end
      // output still held: park the new result in the skid slot
      if (in_valid && out_valid_ff && !out_take) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign busy      = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule
